// ===== design/assert_macros.svh =====
// Assertion helpers, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define WFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define WFT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== design/wft_pkg.sv =====
`default_nettype none
package wft_pkg;

    localparam int SLOT_W  = 4;   // width of the slot field
    localparam int OCNT_W  = 16;  // width of the word_count field

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;  // first of the control spaces
    localparam logic [7:0] CHAR_CR    = 8'h0D;  // last of the control spaces
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFS  = 8'h20;  // 'a' - 'A'

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       store;      // byte goes into the pending word
        logic       first;      // byte is the first of a word
        logic       finish;     // word ends in this cycle
        logic [7:0] char_byte;  // folded byte
    } t_cell_ctl;

    // Handed from each cell to its right-hand neighbour.
    typedef struct packed {
        logic              used;        // this cell holds a word
        logic              hit;         // a cell so far matched
        logic              ins;         // a cell so far took the word
        logic [SLOT_W-1:0] slot;
        logic [OCNT_W-1:0] word_count;
    } t_link;

endpackage
`default_nettype wire

// ===== design/wft_in_if.sv =====
`default_nettype none
interface wft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== design/wft_out_if.sv =====
`default_nettype none
interface wft_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot;
    logic [15:0] word_count;
    logic        new_entry;
    logic        dropped_full;
    logic        truncated;
    logic        last;

    modport source (output valid, output slot, output word_count, output new_entry,
                    output dropped_full, output truncated, output last, input ready);
    modport sink   (input valid, input slot, input word_count, input new_entry,
                    input dropped_full, input truncated, input last, output ready);
endinterface
`default_nettype wire

// ===== design/wft_cell.sv =====
`default_nettype none
module wft_cell import wft_pkg::*; #(
    parameter int WORD_BYTES = 32,
    parameter int COUNT_BITS = 16,
    parameter int INDEX      = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire t_cell_ctl               i_ctl,
    input  wire [$clog2(WORD_BYTES)-1:0] i_pos,
    input  wire [$clog2(WORD_BYTES+1)-1:0] i_len,
    input  wire t_link                   i_link,
    output t_link                        o_link
);
    localparam int LEN_W = $clog2(WORD_BYTES+1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [7:0]            r_key [WORD_BYTES];
    logic [LEN_W-1:0]      r_key_len;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_used;
    logic                  r_match;

    logic                  w_cand;
    logic                  w_match;
    logic                  w_hit;
    logic                  w_ins;
    logic [COUNT_BITS-1:0] w_inc;

    // free cell straight after the last one in use takes the new word
    assign w_cand  = i_link.used & ~r_used;
    assign w_match = i_ctl.store ? ((i_ctl.first | r_match) & (r_key[i_pos] == i_ctl.char_byte))
                                 : r_match;
    assign w_hit   = i_ctl.finish & r_used & w_match & (r_key_len == i_len);
    // all cells in use sit to the left, so the incoming hit is complete here
    assign w_ins   = i_ctl.finish & w_cand & ~i_link.hit;
    assign w_inc   = (r_count == CNT_MAX) ? r_count : r_count + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_count <= '0;
        end else if (w_hit) begin
            r_count <= w_inc;
        end else if (w_ins) begin
            r_used  <= 1'b1;
            r_count <= COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.store) begin
            r_match <= w_match;
            if (w_cand) begin
                r_key[i_pos] <= i_ctl.char_byte;
            end
        end
        if (w_ins) begin
            r_key_len <= i_len;
        end
    end

    always_comb begin
        o_link.used       = r_used;
        o_link.hit        = i_link.hit | w_hit;
        o_link.ins        = i_link.ins | w_ins;
        o_link.slot       = i_link.slot;
        o_link.word_count = i_link.word_count;
        if (w_hit) begin
            o_link.slot       = SLOT_W'(INDEX);
            o_link.word_count = OCNT_W'(w_inc);
        end else if (w_ins) begin
            o_link.slot       = SLOT_W'(INDEX);
            o_link.word_count = OCNT_W'(1);
        end
    end
endmodule
`default_nettype wire

// ===== design/word_frequency_table.sv =====
// Channel   Dir  Payload                                                      Transaction
// i_text    in   char_byte[8], end_of_text                                    one byte of text
// o_result  out  slot[4], word_count[16], new_entry, dropped_full, truncated, last  one word
//
// One byte a cycle while the output register is empty or being drained. Each cell
// compares its stored key against the byte as it arrives, so a word is resolved in
// the cycle that ends it and its result sits in the output register the cycle after;
// the chain of cells is the path that sets the clock period (one link per table entry).
// i_rst_n is synchronous: it empties the table and the pending word.
// A byte is taken whenever the output register is empty or being drained.
`default_nettype none
`include "assert_macros.svh"
module word_frequency_table import wft_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int WORD_BYTES    = 32,
    parameter int COUNT_BITS    = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    wft_in_if.sink       i_text,
    wft_out_if.source    o_result
);
    localparam int POS_W = $clog2(WORD_BYTES);
    localparam int LEN_W = $clog2(WORD_BYTES+1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BYTES);

    // pending word: only its length and cut flag live here, the bytes go
    // straight into the cells
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;

    // output register
    logic              r_oval;
    logic [SLOT_W-1:0] r_slot;
    logic [OCNT_W-1:0] r_count;
    logic              r_new;
    logic              r_drop;
    logic              r_trunc;
    logic              r_last;

    logic             w_take;
    logic             w_space;
    logic             w_ends;
    logic             w_room;
    logic             w_cut;
    logic [7:0]       w_fold;
    logic [LEN_W-1:0] n_len;
    logic             w_finish;
    t_cell_ctl        w_ctl;
    t_link            w_link [TABLE_ENTRIES+1];

    assign i_text.ready = ~r_oval | o_result.ready;
    assign w_take       = i_text.valid & i_text.ready;

    always_comb begin
        case (i_text.char_byte) inside
            CHAR_SPACE, [CHAR_TAB:CHAR_CR]: w_space = 1'b1;
            default:                        w_space = 1'b0;
        endcase
        case (i_text.char_byte) inside
            [CHAR_UP_A:CHAR_UP_Z]: w_fold = i_text.char_byte + CASE_OFFS;
            default:               w_fold = i_text.char_byte;
        endcase
    end

    assign w_ends   = w_space | i_text.end_of_text;
    assign w_room   = r_len < LEN_MAX;
    // byte past the key width: dropped, the word is flagged
    assign w_cut    = ~w_space & ~w_room;
    assign n_len    = (w_take & ~w_space & w_room) ? r_len + LEN_W'(1) : r_len;
    // an empty word gives no transaction
    assign w_finish = w_take & w_ends & (n_len != '0);

    assign w_ctl.store     = w_take & ~w_space & w_room;
    assign w_ctl.first     = (r_len == '0);
    assign w_ctl.finish    = w_finish;
    assign w_ctl.char_byte = w_fold;

    // left end of the chain behaves as a cell in use with nothing found
    assign w_link[0] = '{used: 1'b1, hit: 1'b0, ins: 1'b0, slot: '0, word_count: '0};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        wft_cell #(
            .WORD_BYTES (WORD_BYTES),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pos   (r_len[POS_W-1:0]),
            .i_len   (n_len),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (w_take) begin
            if (w_ends) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_len <= n_len;
                r_ovf <= r_ovf | w_cut;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_finish) begin
            r_oval <= 1'b1;
        end else if (o_result.ready) begin
            r_oval <= 1'b0;
        end
    end

    // no match and no free cell: word dropped, slot and count read zero
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_slot  <= w_link[TABLE_ENTRIES].slot;
            r_count <= w_link[TABLE_ENTRIES].word_count;
            r_new   <= w_link[TABLE_ENTRIES].ins;
            r_drop  <= ~w_link[TABLE_ENTRIES].hit & ~w_link[TABLE_ENTRIES].ins;
            r_trunc <= r_ovf | w_cut;
            r_last  <= i_text.end_of_text;
        end
    end

    assign o_result.valid        = r_oval;
    assign o_result.slot         = r_slot;
    assign o_result.word_count   = r_count;
    assign o_result.new_entry    = r_new;
    assign o_result.dropped_full = r_drop;
    assign o_result.truncated    = r_trunc;
    assign o_result.last         = r_last;

    `WFT_ASSERT(a_finish_shows, w_finish |=> r_oval, "finished word gave no result")
    `WFT_ASSERT(a_drop_full, (r_oval && r_drop) |-> w_link[TABLE_ENTRIES].used, "dropped with room left")
    `WFT_ASSERT(a_new_one, (r_oval && r_new) |-> (r_count == OCNT_W'(1) && !r_drop), "bad new entry")
    `WFT_NEVER(a_len_cap, r_len > LEN_MAX, "pending word longer than key width")
endmodule
`default_nettype wire

// ===== test/word_frequency_table_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module word_frequency_table_tb;
    import wft_pkg::*;

    // Table geometry, as the block is built by default
    localparam int TABLE_ENTRIES = 16;
    localparam int WORD_BYTES    = 32;
    localparam int COUNT_BITS    = 16;

    // Vocabulary used to build word streams; index 0 is the one-letter
    // word that opens a drained block
    localparam int VOCAB     = 24;
    localparam int VOCAB_MAX = 48;

    // Receiver hold-off and the stretch with no idling, in cycles
    localparam int HOLD_AT   = 200;
    localparam int HOLD_LEN  = 400;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO   = 1600;

    typedef struct {
        logic [7:0] char_byte;
        logic       end_of_text;
        bit         drain;        // hold this byte back until every tally is in
    } t_text_item;

    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] word_count;
        logic        new_entry;
        logic        dropped_full;
        logic        truncated;
        logic        last;
    } t_tally;

    logic i_clk;
    logic i_rst_n = 1'b0;

    wft_in_if  text_if ();
    wft_out_if result_if ();

    word_frequency_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_if),
        .o_result (result_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Bytes still to send, and tallies still owed by the block
    t_text_item text_q[$];
    t_tally     tally_q[$];
    t_text_item in_flight;

    int cyc = 0;
    int hold_left = 0;
    int words_predicted = 0;
    int words_seen = 0;
    int faults = 0;
    wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    // Predictor state: pending word and the table of counted words
    logic [7:0]            pend_word [WORD_BYTES];
    int                    pend_len = 0;
    bit                    pend_cut = 1'b0;
    logic [7:0]            key_chr   [TABLE_ENTRIES][WORD_BYTES];
    int                    key_len   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] key_cnt   [TABLE_ENTRIES];
    int                    keys_used = 0;

    logic [7:0] vocab_chr [VOCAB][VOCAB_MAX];
    int         vocab_len [VOCAB];

    // Takes one byte of text into the predicted table; a finished word
    // queues the tally the block owes for it.
    task automatic tally_byte(input logic [7:0] b, input logic eot);
        t_tally t;
        int     e;
        int     hit_at;
        int     i;
        bit     same;
        if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
            if (pend_len < WORD_BYTES) begin
                pend_word[pend_len] = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? b + CASE_OFFS : b;
                pend_len++;
            end else begin
                pend_cut = 1'b1;
            end
            if (!eot) return;
        end
        // empty word: nothing owed, pending state cleared
        if (pend_len == 0) begin
            pend_cut = 1'b0;
            return;
        end

        hit_at = -1;
        for (e = 0; e < keys_used; e++) begin
            if (hit_at < 0 && key_len[e] == pend_len) begin
                same = 1'b1;
                for (i = 0; i < pend_len; i++)
                    if (key_chr[e][i] != pend_word[i]) same = 1'b0;
                if (same) hit_at = e;
            end
        end

        t = '0;
        if (hit_at >= 0) begin
            if (key_cnt[hit_at] != {COUNT_BITS{1'b1}}) key_cnt[hit_at]++;  // saturates
            t.slot       = hit_at[3:0];
            t.word_count = 16'(key_cnt[hit_at]);
        end else if (keys_used < TABLE_ENTRIES) begin
            for (i = 0; i < pend_len; i++) key_chr[keys_used][i] = pend_word[i];
            key_len[keys_used] = pend_len;
            key_cnt[keys_used] = 1;
            t.slot       = keys_used[3:0];
            t.word_count = 16'd1;
            t.new_entry  = 1'b1;
            keys_used++;
        end else begin
            t.dropped_full = 1'b1;  // table full: slot and count stay zero
        end
        t.truncated = pend_cut;
        t.last      = eot;
        tally_q.push_back(t);
        words_predicted++;
        pend_len = 0;
        pend_cut = 1'b0;
    endtask

    task automatic push_item(input logic [7:0] b, input logic eot, input bit drain);
        t_text_item it;
        it.char_byte   = b;
        it.end_of_text = eot;
        it.drain       = drain;
        text_q.push_back(it);
    endtask

    // Any byte that is not whitespace
    function automatic logic [7:0] rand_glyph();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR));
        return b;
    endfunction

    // One vocabulary word in random case, closed by whitespace or by
    // end of text, either on the last letter or on the whitespace
    task automatic push_word(input int w, input bit drain);
        int         i;
        int         k;
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        for (i = 0; i < vocab_len[w]; i++) begin
            b = vocab_chr[w][i];
            if (b >= "a" && b <= "z" && $urandom_range(1) == 1) b = b - CASE_OFFS;
            push_item(b, (pick >= 85) && (i == vocab_len[w] - 1), drain && (i == 0));
        end
        if (pick < 85) begin
            k = $urandom_range(5);
            push_item((k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k), pick >= 70, 1'b0);
            if ($urandom_range(9) == 0) push_item(CHAR_SPACE, 1'b0, 1'b0);
        end
    endtask

    // Mostly well-formed words, the rest raw noise bytes
    task automatic push_random(input int n_items, input bit drain);
        int stop;
        stop = text_q.size() + n_items;
        if (drain) push_word(0, 1'b1);
        while (text_q.size() < stop) begin
            if ($urandom_range(99) < 80)
                push_word($urandom_range(VOCAB - 1), 1'b0);
            else
                push_item(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0);
        end
    endtask

    // Cycle count and the receiver's long hold-off
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Driver: predicts each byte as its transaction completes, then
    // offers the next one unless idling or waiting for the block to drain.
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else begin
            offer = !text_if.valid;
            if (text_if.valid && text_if.ready) begin
                tally_byte(in_flight.char_byte, in_flight.end_of_text);
                offer = 1'b1;
            end
            if (offer) begin
                if (text_q.size() != 0
                        && !(text_q[0].drain && words_seen != words_predicted)
                        && (calm || $urandom_range(99) >= 22)) begin
                    in_flight = text_q.pop_front();
                    text_if.valid       <= 1'b1;
                    text_if.char_byte   <= in_flight.char_byte;
                    text_if.end_of_text <= in_flight.end_of_text;
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each completed result transaction against the
    // oldest tally owed, then chooses ready for the next cycle.
    always @(posedge i_clk) begin
        t_tally want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                words_seen <= words_seen + 1;
                if (tally_q.size() == 0) begin
                    $error("result with no word pending: slot %0d count %0d",
                           result_if.slot, result_if.word_count);
                    faults++;
                end else begin
                    want = tally_q.pop_front();
                    if (result_if.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, result_if.slot);
                        faults++;
                    end
                    if (result_if.word_count !== want.word_count) begin
                        $error("word_count: expected %0d, got %0d",
                               want.word_count, result_if.word_count);
                        faults++;
                    end
                    if (result_if.new_entry !== want.new_entry) begin
                        $error("new_entry: expected %0d, got %0d",
                               want.new_entry, result_if.new_entry);
                        faults++;
                    end
                    if (result_if.dropped_full !== want.dropped_full) begin
                        $error("dropped_full: expected %0d, got %0d",
                               want.dropped_full, result_if.dropped_full);
                        faults++;
                    end
                    if (result_if.truncated !== want.truncated) begin
                        $error("truncated: expected %0d, got %0d",
                               want.truncated, result_if.truncated);
                        faults++;
                    end
                    if (result_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, result_if.last);
                        faults++;
                    end
                end
            end
            result_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 22);
        end
    end

    initial begin
        int w;
        int i;
        text_if.valid       = 1'b0;
        text_if.char_byte   = '0;
        text_if.end_of_text = 1'b0;
        result_if.ready     = 1'b0;

        // vocabulary: a one-letter word, a full-length word, that word
        // run past the key width, a long word of arbitrary bytes, short words
        vocab_chr[0][0] = "x";
        vocab_len[0]    = 1;
        for (i = 0; i < WORD_BYTES; i++) vocab_chr[1][i] = "a" + 8'($urandom_range(25));
        vocab_len[1] = WORD_BYTES;
        for (i = 0; i < WORD_BYTES + 3; i++)
            vocab_chr[2][i] = (i < WORD_BYTES) ? vocab_chr[1][i] : "a" + 8'($urandom_range(25));
        vocab_len[2] = WORD_BYTES + 3;
        for (i = 0; i < 40; i++) vocab_chr[3][i] = rand_glyph();
        vocab_len[3] = 40;
        for (w = 4; w < VOCAB; w++) begin
            vocab_len[w] = $urandom_range(1, 5);
            for (i = 0; i < vocab_len[w]; i++)
                vocab_chr[w][i] = ($urandom_range(3) != 0) ? "a" + 8'($urandom_range(25))
                                                           : rand_glyph();
        end

        // directed: end of text on a letter, empty words, case folding at
        // the edges of A..Z, zero and high bytes, every whitespace byte,
        // neighbours of the whitespace range, a hit by folded case
        push_item("x", 1'b1, 1'b0);
        push_item(CHAR_SPACE, 1'b0, 1'b0);
        push_item(CHAR_TAB, 1'b1, 1'b0);
        push_item("@", 1'b0, 1'b0);
        push_item(CHAR_UP_A, 1'b0, 1'b0);
        push_item(CHAR_UP_Z, 1'b0, 1'b0);
        push_item("[", 1'b0, 1'b0);
        push_item(CHAR_TAB + 8'd1, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(CHAR_TAB + 8'd2, 1'b0, 1'b0);
        push_item(CHAR_TAB - 8'd1, 1'b0, 1'b0);
        push_item(CHAR_CR + 8'd1, 1'b0, 1'b0);
        push_item(CHAR_SPACE - 8'd1, 1'b0, 1'b0);
        push_item(CHAR_SPACE + 8'd1, 1'b0, 1'b0);
        push_item(CHAR_TAB + 8'd3, 1'b0, 1'b0);
        push_item("a", 1'b0, 1'b0);
        push_item("z", 1'b0, 1'b0);
        push_item(CHAR_CR, 1'b1, 1'b0);
        push_item("X", 1'b0, 1'b0);
        push_item(CHAR_SPACE, 1'b0, 1'b0);

        // first random block opens with the full-length, cut and long words
        push_word(1, 1'b1);
        push_word(2, 1'b0);
        push_word(3, 1'b0);
        push_word(3, 1'b0);
        push_random(350, 1'b0);

        push_random(350, 1'b1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || text_if.valid || words_seen != words_predicted)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (tally_q.size() != 0) begin
            $error("%0d results never arrived", tally_q.size());
            faults++;
        end
        if (faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
